@@ rtl/core/sawr_pkg.sv @@
// Package: transaction types and constants for the stop-and-wait receiver.
package sawr_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic        FUNC_HEADER = 1'b0;
  localparam logic        FUNC_DATA   = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] seq_in;
    logic [15:0] sent_checksum;
    logic        final_in;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ack_seq;
    logic        checksum_ok;
    logic        is_new;
    logic        is_duplicate;
    logic        transfer_done;
    logic [31:0] original_count;
    logic [31:0] retransmit_count;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

@@ rtl/core/sawr_crc8.sv @@
// CRC-16/CCITT update by one byte (poly 0x1021, no reflection).
module sawr_crc8 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  byte_in,
  output logic [15:0] crc_out
);

  logic [7:0] x0;
  logic [7:0] x1;

  always_comb begin
    x0      = crc_in[15:8] ^ byte_in;
    x1      = x0 ^ {4'b0, x0[7:4]};
    crc_out = {crc_in[7:0], 8'h00} ^ {x1[3:0], 12'h000} ^ {3'b000, x1, 5'b00000}
              ^ {8'h00, x1};
  end

endmodule

@@ rtl/core/sawr_core.sv @@
// Receiver state: held header, running CRC, sequence tracking, counters.
module sawr_core #(
  parameter int SEQ_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  sawr_pkg::in_item_t item,
  output sawr_pkg::res_t    res
);

  logic [15:0]         crc_r, crc_nxt, crc_upd;
  logic [SEQ_BITS-1:0] held_seq_r, held_seq_nxt;
  logic [15:0]         held_ck_r, held_ck_nxt;
  logic                held_final_r, held_final_nxt;
  logic [SEQ_BITS-1:0] prev_seq_r, prev_seq_nxt;
  logic                prev_valid_r, prev_valid_nxt;
  logic [31:0]         new_cnt_r, new_cnt_nxt;
  logic [31:0]         dup_cnt_r, dup_cnt_nxt;
  logic                done_r, done_nxt;
  logic                ok, fresh, dup;
  logic [SEQ_BITS+15:0] seq_ext;
  logic [SEQ_BITS+15:0] ack_ext;

  sawr_crc8 u_crc (
    .crc_in  (crc_r),
    .byte_in (item.data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    seq_ext        = {{SEQ_BITS{1'b0}}, item.seq_in};
    ack_ext        = {16'h0000, held_seq_r};
    crc_nxt        = crc_r;
    held_seq_nxt   = held_seq_r;
    held_ck_nxt    = held_ck_r;
    held_final_nxt = held_final_r;
    prev_seq_nxt   = prev_seq_r;
    prev_valid_nxt = prev_valid_r;
    new_cnt_nxt    = new_cnt_r;
    dup_cnt_nxt    = dup_cnt_r;
    done_nxt       = done_r;
    ok             = (crc_upd == held_ck_r);
    fresh          = ok && (!prev_valid_r || (prev_seq_r != held_seq_r));
    dup            = ok && !fresh;
    res.valid      = 1'b0;
    if (adv) begin
      if (item.func == sawr_pkg::FUNC_HEADER) begin
        held_seq_nxt   = seq_ext[SEQ_BITS-1:0];
        held_ck_nxt    = item.sent_checksum;
        held_final_nxt = item.final_in;
        crc_nxt        = sawr_pkg::CRC_INIT;
      end else if (!item.last_byte) begin
        crc_nxt = crc_upd;
      end else begin
        crc_nxt   = sawr_pkg::CRC_INIT;
        res.valid = 1'b1;
        if (fresh) begin
          new_cnt_nxt    = (new_cnt_r == '1) ? new_cnt_r : new_cnt_r + 32'd1;
          prev_seq_nxt   = held_seq_r;
          prev_valid_nxt = 1'b1;
          if (held_final_r) done_nxt = 1'b1;
        end else if (dup) begin
          dup_cnt_nxt = (dup_cnt_r == '1) ? dup_cnt_r : dup_cnt_r + 32'd1;
        end
      end
    end
    res.item.ack_seq          = ack_ext[15:0];
    res.item.checksum_ok      = ok;
    res.item.is_new           = fresh;
    res.item.is_duplicate     = dup;
    res.item.transfer_done    = done_nxt;
    res.item.original_count   = new_cnt_nxt;
    res.item.retransmit_count = dup_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= sawr_pkg::CRC_INIT;
      held_seq_r   <= '0;
      held_ck_r    <= '0;
      held_final_r <= 1'b0;
      prev_seq_r   <= '0;
      prev_valid_r <= 1'b0;
      new_cnt_r    <= '0;
      dup_cnt_r    <= '0;
      done_r       <= 1'b0;
    end else begin
      crc_r        <= crc_nxt;
      held_seq_r   <= held_seq_nxt;
      held_ck_r    <= held_ck_nxt;
      held_final_r <= held_final_nxt;
      prev_seq_r   <= prev_seq_nxt;
      prev_valid_r <= prev_valid_nxt;
      new_cnt_r    <= new_cnt_nxt;
      dup_cnt_r    <= dup_cnt_nxt;
      done_r       <= done_nxt;
    end
  end

endmodule

@@ rtl/core/stop_and_wait_receiver_crc_check.sv @@
// Path from input transaction to result transaction: input register, then result register.
// Throughput: one item per cycle while the output is not stalled; the CRC byte update and packet check sit
// between the input register and the result register.
// Only a last payload byte produces a result; headers and other bytes produce none.
// Reset: synchronous, active low; clears both stages, CRC to 0xFFFF, state to zero.
module stop_and_wait_receiver_crc_check #(
  parameter int SEQ_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sawr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sawr_pkg::out_item_t out_data
);

  logic                in_valid_r, in_valid_nxt;
  sawr_pkg::in_item_t  in_item_r;
  logic                out_valid_r, out_valid_nxt;
  sawr_pkg::out_item_t out_item_r;
  logic                adv;
  logic                in_acc;
  sawr_pkg::res_t      res;

  assign adv       = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  sawr_core #(.SEQ_BITS(SEQ_BITS)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .res   (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) in_valid_nxt = 1'b1;
    else if (adv) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (res.valid) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_item_r <= in_data;
    if (res.valid) out_item_r <= res.item;
  end

endmodule

@@ rtl/core/sawr_checker.sv @@
// Port checker for the receiver, bound to the top level.
module sawr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input sawr_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_bad_unsorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.checksum_ok |-> !out_data.is_new && !out_data.is_duplicate)
    else $error("bad packet sorted as new or duplicate");

  a_good_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.checksum_ok |-> out_data.is_new != out_data.is_duplicate)
    else $error("good packet not sorted exactly once");

  a_new_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_new |-> out_data.original_count != 32'd0)
    else $error("new packet not counted");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stop_and_wait_receiver_crc_check sawr_checker u_sawr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ test/tb_stop_and_wait_receiver_crc_check.sv @@
// Self-checking testbench for the stop-and-wait receiver with CRC-16/CCITT packet check.
`timescale 1ns / 100ps

module tb_stop_and_wait_receiver_crc_check;

  typedef logic [7:0] byte_q_t[$];

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sawr_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sawr_pkg::out_item_t out_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  logic        hold_off       = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  logic [15:0] last_seq_sent  = '0;
  sawr_pkg::out_item_t pending_acks[$];

  // receiver state as predicted
  logic [15:0] crc_acc         = sawr_pkg::CRC_INIT;
  logic [15:0] hdr_seq         = '0;
  logic [15:0] hdr_csum        = '0;
  logic        hdr_final       = 1'b0;
  logic [15:0] last_good_seq   = '0;
  logic        last_good_valid = 1'b0;
  logic [31:0] new_pkt_count   = '0;
  logic [31:0] dup_pkt_count   = '0;
  logic        xfer_done       = 1'b0;

  stop_and_wait_receiver_crc_check dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic void update_link_state(input sawr_pkg::in_item_t it);
    sawr_pkg::out_item_t r;
    logic      good;
    logic      fresh;
    if (it.func == sawr_pkg::FUNC_HEADER) begin
      hdr_seq   = it.seq_in;
      hdr_csum  = it.sent_checksum;
      hdr_final = it.final_in;
      crc_acc   = sawr_pkg::CRC_INIT;
    end else begin
      crc_acc = crc16_ccitt(crc_acc, it.data_byte);
      if (it.last_byte) begin
        good  = (crc_acc == hdr_csum);
        fresh = good && (!last_good_valid || last_good_seq != hdr_seq);
        if (fresh) begin
          if (new_pkt_count != '1) new_pkt_count++;
          last_good_seq   = hdr_seq;
          last_good_valid = 1'b1;
          if (hdr_final) xfer_done = 1'b1;
        end else if (good) begin
          if (dup_pkt_count != '1) dup_pkt_count++;
        end
        crc_acc = sawr_pkg::CRC_INIT;
        r.ack_seq          = hdr_seq;
        r.checksum_ok      = good;
        r.is_new           = fresh;
        r.is_duplicate     = good && !fresh;
        r.transfer_done    = xfer_done;
        r.original_count   = new_pkt_count;
        r.retransmit_count = dup_pkt_count;
        pending_acks.push_back(r);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100)
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one transaction; the item is held until accepted
  task automatic send_item(input sawr_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    update_link_state(it);
    items_sent++;
  endtask

  function automatic sawr_pkg::in_item_t header_item(input logic [15:0] seq,
                                                     input logic [15:0] csum,
                                                     input logic fin);
    sawr_pkg::in_item_t it;
    it.func          = sawr_pkg::FUNC_HEADER;
    it.seq_in        = seq;
    it.sent_checksum = csum;
    it.final_in      = fin;
    it.data_byte     = 8'($urandom);
    it.last_byte     = 1'($urandom);
    return it;
  endfunction

  function automatic sawr_pkg::in_item_t byte_item(input logic [7:0] b, input logic is_last);
    sawr_pkg::in_item_t it;
    it.func          = sawr_pkg::FUNC_DATA;
    it.seq_in        = 16'($urandom);
    it.sent_checksum = 16'($urandom);
    it.final_in      = 1'($urandom);
    it.data_byte     = b;
    it.last_byte     = is_last;
    return it;
  endfunction

  function automatic byte_q_t rand_payload(input int unsigned len);
    byte_q_t q;
    repeat (len) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic send_packet(input logic [15:0] seq, input logic fin, input byte_q_t payload,
                             input logic bad);
    logic [15:0] c;
    c = sawr_pkg::CRC_INIT;
    foreach (payload[i]) c = crc16_ccitt(c, payload[i]);
    if (bad) c = c ^ 16'($urandom_range(16'hFFFF, 1));
    send_item(header_item(seq, c, fin));
    foreach (payload[i]) send_item(byte_item(payload[i], i == payload.size() - 1));
    last_seq_sent = seq;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    sawr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_acks.size() == 0) begin
        report_mismatch("result with none pending, ack_seq", 32'(out_data.ack_seq), '0);
      end else begin
        want = pending_acks.pop_front();
        if (out_data.ack_seq !== want.ack_seq)
          report_mismatch("ack_seq", 32'(out_data.ack_seq), 32'(want.ack_seq));
        if (out_data.checksum_ok !== want.checksum_ok)
          report_mismatch("checksum_ok", 32'(out_data.checksum_ok), 32'(want.checksum_ok));
        if (out_data.is_new !== want.is_new)
          report_mismatch("is_new", 32'(out_data.is_new), 32'(want.is_new));
        if (out_data.is_duplicate !== want.is_duplicate)
          report_mismatch("is_duplicate", 32'(out_data.is_duplicate),
                          32'(want.is_duplicate));
        if (out_data.transfer_done !== want.transfer_done)
          report_mismatch("transfer_done", 32'(out_data.transfer_done),
                          32'(want.transfer_done));
        if (out_data.original_count !== want.original_count)
          report_mismatch("original_count", out_data.original_count, want.original_count);
        if (out_data.retransmit_count !== want.retransmit_count)
          report_mismatch("retransmit_count", out_data.retransmit_count,
                          want.retransmit_count);
      end
    end
  end

  task automatic test_directed();
    logic [15:0] c;
    c = crc16_ccitt(sawr_pkg::CRC_INIT, 8'hA5);
    // bytes before any header; trailing CRC bytes give zero, the reset checksum
    send_item(byte_item(8'hA5, 1'b0));
    send_item(byte_item(c[15:8], 1'b0));
    send_item(byte_item(c[7:0], 1'b1));
    send_packet(16'hFFFF, 1'b0, '{8'hFF}, 1'b0);
    send_packet(16'hFFFF, 1'b0, '{8'h00}, 1'b0);
    send_packet(16'h0000, 1'b0, '{8'h00, 8'hFF}, 1'b1);
    // header in mid-packet drops the partial packet
    send_item(header_item(16'h1234, 16'h0000, 1'b0));
    send_item(byte_item(8'h11, 1'b0));
    send_item(byte_item(8'h22, 1'b0));
    send_packet(16'h1235, 1'b0, '{8'h33}, 1'b0);
    // no new header: held header reused
    send_item(byte_item(8'h33, 1'b1));
    // header with no payload
    send_item(header_item(16'h4321, 16'hFFFF, 1'b1));
    send_packet(16'h8000, 1'b1, '{8'h5A, 8'hA5}, 1'b0);
    send_packet(16'h8000, 1'b1, '{8'h01}, 1'b0);
    send_packet(16'h0001, 1'b0, '{8'h7E}, 1'b1);
  endtask

  task automatic test_random(input int unsigned snd_pct, input int unsigned rcv_pct,
                             input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [15:0] seq;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        pick = $urandom_range(99);
        if (pick < 40) seq = last_seq_sent;
        else if (pick < 85) seq = last_seq_sent + 16'd1;
        else if (pick < 95) seq = 16'($urandom);
        else seq = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
        send_packet(seq, $urandom_range(11) == 0, rand_payload(len), $urandom_range(5) == 0);
      end else if (pick < 90) begin
        send_item(byte_item(8'($urandom), 1'($urandom)));
      end else if (pick < 95) begin
        send_item(header_item(16'($urandom), 16'($urandom), 1'($urandom)));
      end else begin
        send_item(header_item(16'($urandom), 16'($urandom), 1'($urandom)));
        repeat ($urandom_range(3, 1)) send_item(byte_item(8'($urandom), 1'b0));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (12)
      send_packet(last_seq_sent + 16'd1, 1'b0, rand_payload($urandom_range(3, 1)), 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(30, 68, 525);
    test_random(68, 30, 525);
    test_random(0, 0, 525);
    test_backpressure();
    wait_drain();
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
